### src/m3i_pkg.sv
// Shared constants, cofactor index table and queue entry type for the 3x3 inverter.
package m3i_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// element products, adjugate, split high part, det terms, determinant
	localparam int PW = 2 * WORD_BITS;
	localparam int AW = 2 * WORD_BITS + 1;
	localparam int HW = WORD_BITS + 1;
	localparam int TW = 3 * WORD_BITS + 1;
	localparam int DW = 3 * WORD_BITS + 3;

	// scaled numerator magnitude and divider compare width
	localparam int NW = AW + 2 * FRAC_BITS;
	localparam int CW = (NW > DW + WORD_BITS) ? NW : DW + WORD_BITS;

	localparam int QDEPTH = 2;
	localparam int QPW = $clog2(QDEPTH);

	// input regs, overflow check, one stage per quotient bit, saturation
	localparam int DIV_LAT = WORD_BITS + 3;

	// adjugate element k = m[a]*m[b] - m[c]*m[d], row-major element indexes
	localparam logic [3:0] ADJ_IDX [0:8][0:3] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
	};

	typedef struct packed {
		logic [8:0][AW-1:0] adj;
		logic [DW-1:0]      det;
		logic               singular;
	} qent_t;

endpackage

### src/matrix3_inverse_top.sv
// Throughput: one matrix per cycle; the divider bank drains the queue every cycle,
// so busy only rises if the two-entry queue between front and dividers fills.
// Each result beat shows for exactly one cycle; the receiver cannot stall it.
// Reset (arst_n low) clears all valid bits and the queue; items in flight are dropped.
module matrix3_inverse_top import m3i_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WORD_BITS-1:0] m00,
	input  logic [WORD_BITS-1:0] m01,
	input  logic [WORD_BITS-1:0] m02,
	input  logic [WORD_BITS-1:0] m10,
	input  logic [WORD_BITS-1:0] m11,
	input  logic [WORD_BITS-1:0] m12,
	input  logic [WORD_BITS-1:0] m20,
	input  logic [WORD_BITS-1:0] m21,
	input  logic [WORD_BITS-1:0] m22,
	output logic                 done,
	output logic [WORD_BITS-1:0] inv00,
	output logic [WORD_BITS-1:0] inv01,
	output logic [WORD_BITS-1:0] inv02,
	output logic [WORD_BITS-1:0] inv10,
	output logic [WORD_BITS-1:0] inv11,
	output logic [WORD_BITS-1:0] inv12,
	output logic [WORD_BITS-1:0] inv20,
	output logic [WORD_BITS-1:0] inv21,
	output logic [WORD_BITS-1:0] inv22,
	output logic                 singular
);

	logic [8:0][WORD_BITS-1:0] m;
	logic [8:0][WORD_BITS-1:0] inv;
	logic                      push, empty, full;
	qent_t                     entry, head;

	assign m = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

	m3i_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.m        (m),
		.push     (push),
		.entry    (entry)
	);

	m3i_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (!empty),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	m3i_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!empty),
		.entry    (head),
		.done     (done),
		.inv      (inv),
		.singular (singular)
	);

	assign busy  = full;
	assign inv00 = inv[0];
	assign inv01 = inv[1];
	assign inv02 = inv[2];
	assign inv10 = inv[3];
	assign inv11 = inv[4];
	assign inv12 = inv[5];
	assign inv20 = inv[6];
	assign inv21 = inv[7];
	assign inv22 = inv[8];

endmodule

### src/m3i_front.sv
// Front pipeline: adjugate, determinant and singular classification.
module m3i_front import m3i_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [8:0][WORD_BITS-1:0] m,
	output logic                      push,
	output qent_t                     entry
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [8:0][WORD_BITS-1:0] m_s1;
	logic signed [PW-1:0]      prod_s2 [18];
	logic [2:0][WORD_BITS-1:0] mr_s2, mr_s3;
	logic signed [AW-1:0]      adj_s3 [9];
	logic signed [AW-1:0]      adj_s4 [9];
	logic signed [AW-1:0]      adj_s5 [9];
	logic signed [AW-1:0]      adj_s6 [9];
	logic signed [WORD_BITS+HW-1:0] ph_s4 [3];
	logic signed [WORD_BITS+HW-1:0] pl_s4 [3];
	logic signed [TW-1:0]      t_s5 [3];
	logic signed [DW-1:0]      det_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		m_s1 <= m;
		for (int k = 0; k < 9; k++) begin
			prod_s2[2*k]   <= $signed(m_s1[ADJ_IDX[k][0]]) * $signed(m_s1[ADJ_IDX[k][1]]);
			prod_s2[2*k+1] <= $signed(m_s1[ADJ_IDX[k][2]]) * $signed(m_s1[ADJ_IDX[k][3]]);
			adj_s3[k] <= AW'(prod_s2[2*k]) - AW'(prod_s2[2*k+1]);
			adj_s4[k] <= adj_s3[k];
			adj_s5[k] <= adj_s4[k];
			adj_s6[k] <= adj_s5[k];
		end
		mr_s2 <= m_s1[2:0];
		mr_s3 <= mr_s2;
		// split the first-row cofactors so each multiply stays near word size
		for (int j = 0; j < 3; j++) begin
			ph_s4[j] <= $signed(mr_s3[j]) * $signed(adj_s3[3*j][AW-1:WORD_BITS]);
			pl_s4[j] <= $signed(mr_s3[j]) * $signed({1'b0, adj_s3[3*j][WORD_BITS-1:0]});
			t_s5[j]  <= (TW'(ph_s4[j]) <<< WORD_BITS) + TW'(pl_s4[j]);
		end
		det_s6 <= DW'(t_s5[0]) + DW'(t_s5[1]) + DW'(t_s5[2]);
	end

	always_comb begin
		for (int k = 0; k < 9; k++)
			entry.adj[k] = adj_s6[k];
		entry.det      = det_s6;
		entry.singular = (det_s6 == '0);
	end

	assign push = v_s6;

endmodule

### src/m3i_queue.sv
// Short queue between the front pipeline and the divider bank.
module m3i_queue import m3i_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wdata,
	input  logic  pop,
	output qent_t head,
	output logic  empty,
	output logic  full
);

	qent_t          mem_q [QDEPTH];
	logic [QPW-1:0] wr_q, rd_q;
	logic [QPW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	assign head  = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QPW+1)'(QDEPTH));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");

endmodule

### src/m3i_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturated Q result.
module m3i_div import m3i_pkg::*; (
	input  logic                 clk,
	input  logic [AW-1:0]        num,
	input  logic [DW-1:0]        den,
	output logic [WORD_BITS-1:0] quo
);

	localparam logic [WORD_BITS-1:0] LIM = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic [AW-1:0] num_abs;
	logic [DW-1:0] den_abs;

	logic [NW-1:0] nmag_sa;
	logic [DW-1:0] dmag_sa;
	logic          neg_sa;

	logic [CW-1:0]        rem_s [WORD_BITS+1];
	logic [WORD_BITS-1:0] qb_s  [WORD_BITS+1];
	logic [DW-1:0]        dm_s  [WORD_BITS+1];
	logic                 neg_s [WORD_BITS+1];
	logic                 ovf_s [WORD_BITS+1];

	logic [WORD_BITS-1:0] sat;

	assign num_abs = num[AW-1] ? (~num + 1'b1) : num;
	assign den_abs = den[DW-1] ? (~den + 1'b1) : den;

	always_ff @(posedge clk) begin
		nmag_sa <= {num_abs, (2*FRAC_BITS)'(0)};
		dmag_sa <= den_abs;
		neg_sa  <= num[AW-1] ^ den[DW-1];
		// quotient needs more than a word: flag it and saturate at the end
		ovf_s[WORD_BITS] <= CW'(nmag_sa) >= (CW'(dmag_sa) << WORD_BITS);
		rem_s[WORD_BITS] <= CW'(nmag_sa);
		qb_s[WORD_BITS]  <= '0;
		dm_s[WORD_BITS]  <= dmag_sa;
		neg_s[WORD_BITS] <= neg_sa;
	end

	for (genvar i = 0; i < WORD_BITS; i++) begin : g_bit
		logic [CW-1:0] shd;
		assign shd = CW'(dm_s[i+1]) << i;
		always_ff @(posedge clk) begin
			if (rem_s[i+1] >= shd) begin
				rem_s[i] <= rem_s[i+1] - shd;
				qb_s[i]  <= qb_s[i+1] | (WORD_BITS'(1) << i);
			end else begin
				rem_s[i] <= rem_s[i+1];
				qb_s[i]  <= qb_s[i+1];
			end
			dm_s[i]  <= dm_s[i+1];
			neg_s[i] <= neg_s[i+1];
			ovf_s[i] <= ovf_s[i+1];
		end
	end

	always_comb begin
		priority if (ovf_s[0])
			sat = neg_s[0] ? LIM : LIM - 1'b1;
		else if (neg_s[0])
			sat = (qb_s[0] > LIM) ? LIM : (~qb_s[0] + 1'b1);
		else
			sat = (qb_s[0] > LIM - 1'b1) ? LIM - 1'b1 : qb_s[0];
	end

	always_ff @(posedge clk) begin
		quo <= sat;
	end

endmodule

### src/m3i_back.sv
// Back end: nine dividers in lockstep, singular masking and result register.
module m3i_back import m3i_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  qent_t                     entry,
	output logic                      done,
	output logic [8:0][WORD_BITS-1:0] inv,
	output logic                      singular
);

	logic [DIV_LAT-1:0]        vld_s;
	logic [DIV_LAT-1:0]        sing_s;
	logic [8:0][WORD_BITS-1:0] quo;

	for (genvar k = 0; k < 9; k++) begin : g_div
		m3i_div u_div (
			.clk (clk),
			.num (entry.adj[k]),
			.den (entry.det),
			.quo (quo[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[DIV_LAT-2:0], in_valid};
			done  <= vld_s[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		sing_s   <= {sing_s[DIV_LAT-2:0], entry.singular};
		singular <= sing_s[DIV_LAT-1];
		// zero determinant: drop the divider output
		inv      <= sing_s[DIV_LAT-1] ? '0 : quo;
	end

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && singular) |-> (inv == '0)) else $error("singular beat with nonzero result");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(in_valid, DIV_LAT + 1)) else $error("result beat without source");

endmodule
